[rtl/tesn_pkg.sv]
package tesn_pkg;

  localparam int unsigned MAX_PORTS  = 8;
  localparam int unsigned DIST_WIDTH = 16;
  localparam int unsigned PORT_W     = $clog2(MAX_PORTS);
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0] PORT_COUNT_RST = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX        = CNT_W'((MAX_PORTS < 8) ? MAX_PORTS : 8);

  // input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_SAT   = 2'd1;
  localparam logic [1:0] FUNC_RES   = 2'd2;

  // outgoing message kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_RES  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_START,
    CMD_MSG
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACTIVE,
    PH_PROC,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_ONE,
    BS_SCAN,
    BS_RES
  } bstate_e;

  typedef struct packed {
    cmd_e                  op;
    logic [PORT_W-1:0]     port;
    logic [DIST_WIDTH-1:0] distance;
  } cmd_t;

  // ones for the ports below cnt
  function automatic logic [MAX_PORTS-1:0] low_mask(input logic [CNT_W-1:0] cnt);
    logic [MAX_PORTS-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_PORTS; i++) begin
      m[i] = (i < int'(cnt));
    end
    return m;
  endfunction

endpackage

[rtl/tesn_front.sv]
module tesn_front
  import tesn_pkg::*;
(
  input  logic [1:0]            func_i,
  input  logic [PORT_W-1:0]     port_i,
  input  logic [15:0]           dist_req_i,
  input  logic [CNT_W-1:0]      cnt_i,
  output cmd_t                  cmd_o
);

  logic [DIST_WIDTH-1:0] dist_clamp;
  logic [DIST_WIDTH-1:0] dist_inc;
  logic [CNT_W-1:0]      port_ext;

  // clamp to the distance range, then add one with saturation
  always_comb begin
    if (DIST_WIDTH < 16 && (dist_req_i > 16'({DIST_WIDTH{1'b1}}))) begin
      dist_clamp = '1;
    end else begin
      dist_clamp = DIST_WIDTH'(dist_req_i);
    end
    dist_inc = (&dist_clamp) ? dist_clamp : dist_clamp + DIST_WIDTH'(1);
  end

  // classify the item
  always_comb begin
    port_ext       = CNT_W'(port_i);
    cmd_o.port     = port_i;
    cmd_o.distance = dist_inc;
    if (func_i == FUNC_START) begin
      cmd_o.op = CMD_START;
    end else if ((func_i == FUNC_SAT || func_i == FUNC_RES) && (port_ext < cnt_i)) begin
      cmd_o.op = CMD_MSG;
    end else begin
      cmd_o.op = CMD_NOP;
    end
  end

endmodule

[rtl/tesn_cmd_fifo.sv]
module tesn_cmd_fifo
  import tesn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t rdata_o
);

  cmd_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0]   wptr_q, wptr_d;
  logic [FIFO_PW-1:0]   rptr_q, rptr_d;
  logic [FIFO_PW:0]     fill_q, fill_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (fill_q == (FIFO_PW + 1)'(FIFO_DEPTH));
  assign valid_o = (fill_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + FIFO_PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + FIFO_PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + (FIFO_PW + 1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (FIFO_PW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/tesn_back.sv]
module tesn_back
  import tesn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  sends_o,
  output logic [PORT_W-1:0]     out_port_o,
  output logic [1:0]            out_kind_o,
  output logic [DIST_WIDTH-1:0] out_dist_o,
  output logic [DIST_WIDTH-1:0] eccentricity_o,
  output logic                  finished_o,
  output logic                  last_o
);

  // node state
  phase_e                phase_q, phase_d;
  logic [MAX_PORTS-1:0]  unheard_q, unheard_d;
  logic [PORT_W-1:0]     parent_q, parent_d;
  logic [DIST_WIDTH-1:0] lmax_q, lmax_d;
  logic [DIST_WIDTH-1:0] ecc_q, ecc_d;
  logic                  resolved_q, resolved_d;
  logic [DIST_WIDTH-1:0] pdist_q [MAX_PORTS];
  logic                  pd_we;
  logic                  pd_clr;
  logic [PORT_W-1:0]     pd_addr;
  logic [DIST_WIDTH-1:0] pd_wdata;

  // sequencer
  bstate_e               bst_q, bst_d;
  logic [PORT_W-1:0]     idx_q, idx_d;
  logic [DIST_WIDTH-1:0] max1_q, max1_d;
  logic [DIST_WIDTH-1:0] max2_q, max2_d;
  logic [PORT_W-1:0]     idx1_q, idx1_d;
  logic                  st_sends_q, st_sends_d;
  logic [PORT_W-1:0]     st_port_q, st_port_d;
  logic [1:0]            st_kind_q, st_kind_d;
  logic [DIST_WIDTH-1:0] st_dist_q, st_dist_d;

  // output register
  logic                  ov_q, ov_d;
  logic                  o_sends_q;
  logic [PORT_W-1:0]     o_port_q;
  logic [1:0]            o_kind_q;
  logic [DIST_WIDTH-1:0] o_dist_q;
  logic [DIST_WIDTH-1:0] o_ecc_q;
  logic                  o_fin_q;
  logic                  o_last_q;
  logic                  ld;
  logic                  ld_sends;
  logic [PORT_W-1:0]     ld_port;
  logic [1:0]            ld_kind;
  logic [DIST_WIDTH-1:0] ld_dist;
  logic                  ld_last;

  logic                  out_free;
  logic [PORT_W-1:0]     cnt_m1;
  logic [MAX_PORTS-1:0]  mask_clr;
  logic                  one_left;
  logic [PORT_W-1:0]     enc;
  logic [DIST_WIDTH-1:0] new_max;
  logic [DIST_WIDTH-1:0] scan_d;
  logic                  emit_last;

  assign out_free = !ov_q || out_ready_i;
  assign cnt_m1   = PORT_W'(cnt_i - CNT_W'(1));
  assign mask_clr = unheard_q & ~(MAX_PORTS'(1) << cmd_i.port);
  assign one_left = (mask_clr != '0) && ((mask_clr & (mask_clr - MAX_PORTS'(1))) == '0);
  assign new_max  = (cmd_i.distance > lmax_q) ? cmd_i.distance : lmax_q;
  assign scan_d   = pdist_q[idx_q];
  assign emit_last = (idx_q == cnt_m1) ||
                     ((idx_q + PORT_W'(1) == cnt_m1) && (parent_q == cnt_m1));

  // index of the one remaining unheard port
  always_comb begin
    enc = '0;
    for (int i = 0; i < MAX_PORTS; i++) begin
      if (mask_clr[i]) begin
        enc = PORT_W'(i);
      end
    end
  end

  // sequencer: state update, top-two scan, result emission
  always_comb begin
    bst_d      = bst_q;
    phase_d    = phase_q;
    unheard_d  = unheard_q;
    parent_d   = parent_q;
    lmax_d     = lmax_q;
    ecc_d      = ecc_q;
    resolved_d = resolved_q;
    idx_d      = idx_q;
    max1_d     = max1_q;
    max2_d     = max2_q;
    idx1_d     = idx1_q;
    st_sends_d = st_sends_q;
    st_port_d  = st_port_q;
    st_kind_d  = st_kind_q;
    st_dist_d  = st_dist_q;
    pd_we      = 1'b0;
    pd_clr     = 1'b0;
    pd_addr    = cmd_i.port;
    pd_wdata   = cmd_i.distance;
    cmd_pop_o  = 1'b0;
    ld         = 1'b0;
    ld_sends   = st_sends_q;
    ld_port    = st_port_q;
    ld_kind    = st_kind_q;
    ld_dist    = st_dist_q;
    ld_last    = 1'b1;

    unique case (bst_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          bst_d      = BS_ONE;
          st_sends_d = 1'b0;
          st_port_d  = '0;
          st_kind_d  = KIND_NONE;
          st_dist_d  = '0;
          unique case (cmd_i.op)
            CMD_START: begin
              if (phase_q == PH_IDLE) begin
                unheard_d  = low_mask(cnt_i);
                pd_clr     = 1'b1;
                lmax_d     = '0;
                ecc_d      = '0;
                resolved_d = 1'b0;
                if (cnt_i == CNT_W'(1)) begin
                  parent_d   = '0;
                  phase_d    = PH_PROC;
                  st_sends_d = 1'b1;
                  st_kind_d  = KIND_UP;
                end else begin
                  phase_d = PH_ACTIVE;
                end
              end
            end
            CMD_MSG: begin
              if (phase_q == PH_ACTIVE && unheard_q[cmd_i.port]) begin
                pd_we     = 1'b1;
                lmax_d    = new_max;
                unheard_d = mask_clr;
                if (one_left) begin
                  parent_d   = enc;
                  phase_d    = PH_PROC;
                  st_sends_d = 1'b1;
                  st_port_d  = enc;
                  st_kind_d  = KIND_UP;
                  st_dist_d  = new_max;
                end
              end else if (phase_q == PH_PROC && cmd_i.port == parent_q) begin
                pd_we      = 1'b1;
                ecc_d      = (cmd_i.distance >= lmax_q) ? cmd_i.distance : lmax_q;
                resolved_d = 1'b1;
                phase_d    = PH_DONE;
                if (cnt_i != CNT_W'(1)) begin
                  idx_d  = '0;
                  max1_d = '0;
                  max2_d = '0;
                  idx1_d = '0;
                  bst_d  = BS_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      BS_ONE: begin
        if (out_free) begin
          ld    = 1'b1;
          bst_d = BS_IDLE;
        end
      end
      BS_SCAN: begin
        // keep the largest distance, its port and the runner-up
        if (scan_d > max1_q) begin
          max2_d = max1_q;
          max1_d = scan_d;
          idx1_d = idx_q;
        end else if (scan_d > max2_q) begin
          max2_d = scan_d;
        end
        if (idx_q == cnt_m1) begin
          idx_d = '0;
          bst_d = BS_RES;
        end else begin
          idx_d = idx_q + PORT_W'(1);
        end
      end
      BS_RES: begin
        if (idx_q == parent_q) begin
          idx_d = idx_q + PORT_W'(1);
          if (idx_q == cnt_m1) begin
            bst_d = BS_IDLE;
          end
        end else if (out_free) begin
          ld       = 1'b1;
          ld_sends = 1'b1;
          ld_port  = idx_q;
          ld_kind  = KIND_RES;
          ld_dist  = (idx_q == idx1_q) ? max2_q : max1_q;
          ld_last  = emit_last;
          idx_d    = idx_q + PORT_W'(1);
          if (emit_last) begin
            bst_d = BS_IDLE;
          end
        end
      end
      default: begin
        bst_d = BS_IDLE;
      end
    endcase
  end

  assign ov_d = ld ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_q      <= BS_IDLE;
      phase_q    <= PH_IDLE;
      unheard_q  <= low_mask(PORT_COUNT_RST);
      parent_q   <= '0;
      lmax_q     <= '0;
      ecc_q      <= '0;
      resolved_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      bst_q      <= bst_d;
      phase_q    <= phase_d;
      unheard_q  <= unheard_d;
      parent_q   <= parent_d;
      lmax_q     <= lmax_d;
      ecc_q      <= ecc_d;
      resolved_q <= resolved_d;
      ov_q       <= ov_d;
    end
  end

  // sequencer payload and output register payload
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    max1_q     <= max1_d;
    max2_q     <= max2_d;
    idx1_q     <= idx1_d;
    st_sends_q <= st_sends_d;
    st_port_q  <= st_port_d;
    st_kind_q  <= st_kind_d;
    st_dist_q  <= st_dist_d;
    if (ld) begin
      o_sends_q <= ld_sends;
      o_port_q  <= ld_port;
      o_kind_q  <= ld_kind;
      o_dist_q  <= ld_dist;
      o_ecc_q   <= ecc_q;
      o_fin_q   <= resolved_q;
      o_last_q  <= ld_last;
    end
  end

  // per-port recorded distances
  always_ff @(posedge clk_i) begin
    if (pd_clr) begin
      for (int i = 0; i < MAX_PORTS; i++) begin
        pdist_q[i] <= '0;
      end
    end else if (pd_we) begin
      pdist_q[pd_addr] <= pd_wdata;
    end
  end

  assign out_valid_o    = ov_q;
  assign sends_o        = o_sends_q;
  assign out_port_o     = o_port_q;
  assign out_kind_o     = o_kind_q;
  assign out_dist_o     = o_dist_q;
  assign eccentricity_o = o_ecc_q;
  assign finished_o     = o_fin_q;
  assign last_o         = o_last_q;

endmodule

[rtl/tree_eccentricity_saturation_node.sv]
// One node of the tree saturation eccentricity algorithm. Messages enter on the slave stream
// (tuser = function: start, saturation/upward, resolution) and every item yields its outgoing
// messages in port order, or one status result when nothing is sent; tlast marks the final
// result of an item. The front classifies items into a two-entry command queue, so input
// transfers continue while results wait on the master side. Start and upward items pass
// through the command queue, the sequencer and the output register. For a resolution the
// sequencer sweeps the port distance registers once, a port per cycle, to find the two
// largest distances, then emits a resolution message to each port but the parent. Distances
// saturate at all ones. The user must write port_count through cfg_we_i only while the node
// is idle; the block does not enforce this. port_count is clamped to 1 .. 8.
module tree_eccentricity_saturation_node
  import tesn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // port[2:0], dist_req[18:3], zero fill
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_port[2:0], out_dist[18:3], eccentricity[34:19],
                                     // finished[35], zero fill
  output logic [2:0]  m_axis_tuser,  // sends[0], out_kind[2:1]
  output logic        m_axis_tlast
);

  logic [CNT_W-1:0]      port_count_q;
  logic [CNT_W-1:0]      cnt;
  cmd_t                  fr_cmd;
  cmd_t                  q_cmd;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  sends;
  logic [PORT_W-1:0]     out_port;
  logic [1:0]            out_kind;
  logic [DIST_WIDTH-1:0] out_dist;
  logic [DIST_WIDTH-1:0] ecc;
  logic                  finished;

  // port count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_count_q <= PORT_COUNT_RST;
    end else if (cfg_we_i) begin
      port_count_q <= cfg_wdata_i;
    end
  end

  // effective port count
  always_comb begin
    if (port_count_q == '0) begin
      cnt = CNT_W'(1);
    end else if (port_count_q > CNT_MAX) begin
      cnt = CNT_MAX;
    end else begin
      cnt = port_count_q;
    end
  end

  tesn_front u_front (
    .func_i     (s_axis_tuser),
    .port_i     (s_axis_tdata[2:0]),
    .dist_req_i (s_axis_tdata[18:3]),
    .cnt_i      (cnt),
    .cmd_o      (fr_cmd)
  );

  assign s_axis_tready = !q_full;

  tesn_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (fr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_cmd)
  );

  tesn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cnt_i          (cnt),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .cmd_pop_o      (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .sends_o        (sends),
    .out_port_o     (out_port),
    .out_kind_o     (out_kind),
    .out_dist_o     (out_dist),
    .eccentricity_o (ecc),
    .finished_o     (finished),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, finished, ecc, out_dist, out_port};
  assign m_axis_tuser = {out_kind, sends};

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tesn_pkg::*;

  // unused function code, ignored by the node
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 318;
  // covers the longest resolution sweep with margin
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef struct packed {
    logic                  sends;
    logic [2:0]            out_port;
    logic [1:0]            out_kind;
    logic [DIST_WIDTH-1:0] out_dist;
    logic [DIST_WIDTH-1:0] ecc;
    logic                  finished;
    logic                  last;
  } node_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [3:0]            cfg_val;
    logic [1:0]            func;
    logic [2:0]            port;
    logic [DIST_WIDTH-1:0] distance;
    bit                    typed;
  } stim_row_t;

  // status result of a node that has not started
  localparam node_result_t IDLE_STATUS = '{sends: 1'b0, out_port: 3'd0, out_kind: KIND_NONE,
                                           out_dist: '0, ecc: '0, finished: 1'b0,
                                           last: 1'b1};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // port[2:0], dist_req[18:3], zero fill
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_port[2:0], out_dist[18:3], eccentricity[34:19],
                               // finished[35], zero fill
  logic [2:0]  m_axis_tuser;   // sends[0], out_kind[2:1]
  logic        m_axis_tlast;

  tree_eccentricity_saturation_node i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the node state
  logic [3:0]            port_count_q;
  phase_e                phase_q;
  logic [7:0]            unheard_q;
  logic [2:0]            parent_q;
  logic [DIST_WIDTH-1:0] local_max_q;
  logic [DIST_WIDTH-1:0] port_dist_q [8];
  logic [DIST_WIDTH-1:0] ecc_q;
  logic                  resolved_q;

  node_result_t expected_q [$];
  stim_row_t    stim_rows [$];
  int unsigned  errors = 0;
  int unsigned  burst_left = 0;

  function automatic int unsigned ports_in_use();
    if (port_count_q == 4'd0) return 1;
    if (port_count_q > 4'd8) return 8;
    return int'(port_count_q);
  endfunction

  function automatic logic [7:0] mask_below(input int unsigned n);
    return 8'((9'd1 << n) - 9'd1);
  endfunction

  function automatic logic [DIST_WIDTH-1:0] dist_plus_one(input logic [DIST_WIDTH-1:0] d);
    return (d == '1) ? d : d + 1'b1;
  endfunction

  function automatic void push_result(input logic sends, input logic [2:0] p,
                                      input logic [1:0] kind, input logic [DIST_WIDTH-1:0] d);
    node_result_t r;
    r.sends    = sends;
    r.out_port = p;
    r.out_kind = kind;
    r.out_dist = d;
    r.ecc      = ecc_q;
    r.finished = resolved_q;
    r.last     = 1'b0;
    expected_q.push_back(r);
  endfunction

  // advance the shadow state by one input transfer and queue its results
  function automatic void predict_node(input logic [1:0] func, input logic [2:0] port,
                                       input logic [DIST_WIDTH-1:0] distance);
    int unsigned           cnt;
    int unsigned           n0;
    logic [DIST_WIDTH-1:0] d;
    logic [DIST_WIDTH-1:0] best;
    cnt = ports_in_use();
    n0  = expected_q.size();
    if (func == FUNC_START) begin
      if (phase_q == PH_IDLE) begin
        unheard_q = mask_below(cnt);
        for (int i = 0; i < 8; i++) port_dist_q[i] = '0;
        local_max_q = '0;
        ecc_q       = '0;
        resolved_q  = 1'b0;
        if (cnt == 1) begin
          // leaf: report distance 0 to the only neighbour
          parent_q = 3'd0;
          phase_q  = PH_PROC;
          push_result(1'b1, 3'd0, KIND_UP, '0);
        end else begin
          phase_q = PH_ACTIVE;
        end
      end
    end else if ((func == FUNC_SAT || func == FUNC_RES) && port < cnt) begin
      if (phase_q == PH_ACTIVE && unheard_q[port]) begin
        d = dist_plus_one(distance);
        port_dist_q[port] = d;
        if (d > local_max_q) local_max_q = d;
        unheard_q[port] = 1'b0;
        // one port left unheard: it becomes the parent
        if (unheard_q != '0 && (unheard_q & (unheard_q - 8'd1)) == '0) begin
          for (int i = 0; i < cnt; i++) if (unheard_q[i]) parent_q = 3'(i);
          phase_q = PH_PROC;
          push_result(1'b1, parent_q, KIND_UP, local_max_q);
        end
      end else if (phase_q == PH_PROC && port == parent_q) begin
        d = dist_plus_one(distance);
        port_dist_q[port] = d;
        ecc_q      = (d >= local_max_q) ? d : local_max_q;
        resolved_q = 1'b1;
        phase_q    = PH_DONE;
        // resolution to every other port, max distance excluding the recipient
        for (int i = 0; i < cnt; i++) begin
          if (i != int'(port)) begin
            best = '0;
            for (int j = 0; j < cnt; j++)
              if (j != i && port_dist_q[j] > best) best = port_dist_q[j];
            push_result(1'b1, 3'(i), KIND_RES, best);
          end
        end
      end
    end
    if (expected_q.size() == n0) push_result(1'b0, 3'd0, KIND_NONE, '0);
    expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [DIST_WIDTH-1:0] rand_dist();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {{(DIST_WIDTH-1){1'b1}}, 1'b0};
      default: return DIST_WIDTH'($urandom);
    endcase
  endfunction

  function automatic void add_msg(input logic [1:0] f, input logic [2:0] p,
                                  input logic [DIST_WIDTH-1:0] d, input bit typed);
    stim_row_t r;
    r.is_cfg   = 1'b0;
    r.cfg_val  = '0;
    r.func     = f;
    r.port     = p;
    r.distance = d;
    r.typed    = typed;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [3:0] v);
    stim_row_t r;
    r.is_cfg   = 1'b1;
    r.cfg_val  = v;
    r.func     = FUNC_START;
    r.port     = '0;
    r.distance = '0;
    r.typed    = 1'b0;
    stim_rows.push_back(r);
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic send_item(input logic [1:0] func, input logic [2:0] port,
                           input logic [DIST_WIDTH-1:0] distance, input bit typed,
                           input node_result_t want);
    int unsigned n0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = {5'd0, distance, port};
    do @(posedge clk_i); while (!s_axis_tready);
    n0 = expected_q.size();
    predict_node(func, port, distance);
    if (typed) begin
      while (expected_q.size() > n0) void'(expected_q.pop_back());
      expected_q.push_back(want);
    end
    @(negedge clk_i);
  endtask

  // register write once the node has drained; called at a falling edge
  task automatic write_port_count(input logic [3:0] v);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    port_count_q = v;
    if (phase_q == PH_IDLE) unheard_q = mask_below(ports_in_use());
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic void report_field(input string name, input logic [DIST_WIDTH-1:0] want,
                                       input logic [DIST_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    node_result_t got;
    node_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sends    = m_axis_tuser[0];
      got.out_kind = m_axis_tuser[2:1];
      got.out_port = m_axis_tdata[2:0];
      got.out_dist = m_axis_tdata[18:3];
      got.ecc      = m_axis_tdata[34:19];
      got.finished = m_axis_tdata[35];
      got.last     = m_axis_tlast;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        report_field("sends", 16'(want.sends), 16'(got.sends));
        report_field("out_port", 16'(want.out_port), 16'(got.out_port));
        report_field("out_kind", 16'(want.out_kind), 16'(got.out_kind));
        report_field("out_dist", want.out_dist, got.out_dist);
        report_field("eccentricity", want.ecc, got.ecc);
        report_field("finished", 16'(want.finished), 16'(got.finished));
        report_field("last", 16'(want.last), 16'(got.last));
      end
    end
  end

  // receiver stalls, the pattern switches at random between four modes
  initial begin : ready_pattern
    int unsigned mode;
    int unsigned k;
    mode = 0;
    k    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      k++;
      if (k % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = 1'($urandom_range(0, 1));
        2:       m_axis_tready = (k % 4 == 0);
        default: m_axis_tready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : watchdog
    #(2_000_000);
    $display("tree_eccentricity_saturation_node verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [3:0]            run_count;
    int unsigned           cands [$];
    logic [1:0]            f;
    logic [2:0]            p;
    logic [DIST_WIDTH-1:0] d;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_START;

    port_count_q = PORT_COUNT_RST;
    phase_q      = PH_IDLE;
    unheard_q    = mask_below(ports_in_use());
    parent_q     = '0;
    local_max_q  = '0;
    for (int i = 0; i < 8; i++) port_dist_q[i] = '0;
    ecc_q        = '0;
    resolved_q   = 1'b0;

    // size of the node for its one run: leaf, full, or in between
    case ($urandom_range(0, 3))
      0:       run_count = 4'($urandom_range(0, 1));
      1, 2:    run_count = 4'($urandom_range(8, 15));
      default: run_count = 4'($urandom_range(2, 7));
    endcase

    // directed rows: messages before start, count extremes, start and re-start
    add_msg(FUNC_SAT, 3'd0, 16'h0000, 1'b1);
    add_msg(FUNC_RES, 3'd7, 16'hFFFF, 1'b1);
    add_msg(FUNC_NONE, 3'd5, 16'hAAAA, 1'b1);
    add_cfg(4'd0);
    add_msg(FUNC_SAT, 3'd0, 16'h5555, 1'b1);
    add_cfg(4'd15);
    add_msg(FUNC_RES, 3'd3, 16'h8001, 1'b1);
    add_cfg(4'd8);
    add_cfg(run_count);
    add_msg(FUNC_START, 3'd7, 16'hFFFF, 1'b0);
    add_msg(FUNC_START, 3'd0, 16'h0000, 1'b0);
    add_msg(FUNC_NONE, 3'd0, 16'h1234, 1'b0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_port_count(stim_rows[i].cfg_val);
      else send_item(stim_rows[i].func, stim_rows[i].port, stim_rows[i].distance,
                     stim_rows[i].typed, IDLE_STATUS);
    end

    // random part: messages that move the node on, mixed with noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_q == PH_DONE && n % 80 == 79) write_port_count(4'($urandom_range(0, 15)));
      f = 2'($urandom_range(0, 3));
      p = 3'($urandom_range(0, 7));
      d = rand_dist();
      case (phase_q)
        PH_IDLE: f = FUNC_START;
        PH_ACTIVE: begin
          if ($urandom_range(0, 9) < 7) begin
            cands.delete();
            for (int i = 0; i < ports_in_use(); i++) if (unheard_q[i]) cands.push_back(i);
            p = 3'(cands[$urandom_range(0, cands.size() - 1)]);
            f = $urandom_range(0, 1) ? FUNC_SAT : FUNC_RES;
          end
        end
        PH_PROC: begin
          if ($urandom_range(0, 9) < 4) begin
            p = parent_q;
            f = $urandom_range(0, 1) ? FUNC_SAT : FUNC_RES;
          end
        end
        default: ;
      endcase
      send_item(f, p, d, 1'b0, IDLE_STATUS);
    end

    // drain and let the node settle
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(negedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tree_eccentricity_saturation_node verification clean");
    end else begin
      $display("tree_eccentricity_saturation_node verification failed");
    end
    $finish;
  end

endmodule
